>>> sv/bip_pkg.sv
// Shared constants, types and the precedence function of the infix-to-postfix converter.
`default_nettype none
package bip_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UV    = 8'h56;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LV    = 8'h76;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // offset of the uppercase letters in the seen-letter map
    localparam logic [7:0] UPPER_BASE = 8'd26;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_UNBAL   = 2'd2;

    localparam int LETTER_BITS = 52;

    // request to the seen-letter tracker
    typedef struct packed {
        logic       mark;
        logic       clear;
        logic [7:0] ch;
    } bip_let_cmd_t;

    // '(' ranks lowest, negation highest
    function automatic logic [2:0] rank_of(input logic [7:0] c);
        logic [2:0] r;
        r = 3'd0;
        if (c == CH_EQ)
            r = 3'd1;
        else if (c == CH_GT)
            r = 3'd2;
        else if (c == CH_LV || c == CH_UV)
            r = 3'd3;
        else if (c == CH_AMP || c == CH_CARET)
            r = 3'd4;
        else if (c == CH_TILDE || c == CH_MINUS)
            r = 3'd5;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/bip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/bip_letters.sv
// Seen-letter map and distinct letter counter.
`default_nettype none
module bip_letters
    import bip_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire bip_let_cmd_t cmd,
    output logic [5:0]        count
);

    logic [LETTER_BITS-1:0] seen_reg, seen_next;
    logic [5:0]             count_reg, count_next;
    logic [7:0]             idx_wide;
    logic [5:0]             idx;

    always_comb
    begin
        if (cmd.ch >= CH_LA)
            idx_wide = cmd.ch - CH_LA;
        else
            idx_wide = cmd.ch - CH_UA + UPPER_BASE;
        idx = idx_wide[5:0];
    end

    always_comb
    begin
        seen_next  = seen_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            seen_next  = '0;
            count_next = '0;
        end
        else if (cmd.mark && !seen_reg[idx])
        begin
            seen_next[idx] = 1'b1;
            count_next     = count_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            seen_reg  <= seen_next;
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule
`default_nettype wire

>>> sv/bip_ctrl.sv
// Sequencer: classifies characters, pushes and pops the operator stack RAM, drives the output.
`default_nettype none
module bip_ctrl
    import bip_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [15:0]                    m_tdata,
    output logic                                m_tlast,
    output logic                                ram_we,
    output logic      [$clog2(STACK_DEPTH)-1:0] ram_waddr,
    output logic      [7:0]                     ram_wdata,
    output logic                                ram_re,
    output logic      [$clog2(STACK_DEPTH)-1:0] ram_raddr,
    input  wire logic [7:0]                     ram_rdata,
    output bip_let_cmd_t                        let_cmd,
    input  wire logic [5:0]                     let_count
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam logic [PW-1:0] SP_FULL = PW'(STACK_DEPTH);
    localparam logic [PW-1:0] SP_ONE  = PW'(1);
    localparam logic [PW-1:0] SP_TWO  = PW'(2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_TAIL = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        MODE_BIN   = 2'd0,
        MODE_CLOSE = 2'd1,
        MODE_FLUSH = 2'd2
    } mode_t;

    state_t      state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic [7:0]  op_reg, op_next;
    logic        bad_reg, bad_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_char_reg, pend_char_next;
    logic [1:0]  pend_stat_reg, pend_stat_next;
    logic        fin_valid_reg, fin_valid_next;
    logic [7:0]  fin_char_reg, fin_char_next;
    logic [1:0]  fin_stat_reg, fin_stat_next;
    logic        fin_clear_reg, fin_clear_next;
    logic        oval_reg, oval_next;
    logic [7:0]  ochar_reg, ochar_next;
    logic [5:0]  ocount_reg, ocount_next;
    logic [1:0]  ostat_reg, ostat_next;
    logic        olast_reg, olast_next;

    logic [PW-1:0] sp_m1, sp_m2;
    logic        out_free;
    logic        is_letter, is_unary, is_binary;
    logic        pop_it, top_bad;

    assign sp_m1    = sp_reg - SP_ONE;
    assign sp_m2    = sp_reg - SP_TWO;
    assign out_free = !oval_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        is_letter = ((s_tdata >= CH_LA && s_tdata <= CH_LZ) ||
                     (s_tdata >= CH_UA && s_tdata <= CH_UZ)) &&
                    s_tdata != CH_LV && s_tdata != CH_UV;
        is_unary  = s_tdata == CH_TILDE || s_tdata == CH_MINUS || s_tdata == CH_LP;
        is_binary = s_tdata == CH_EQ || s_tdata == CH_GT || s_tdata == CH_LV ||
                    s_tdata == CH_UV || s_tdata == CH_AMP || s_tdata == CH_CARET;
        top_bad   = (mode_reg == MODE_FLUSH) && (ram_rdata == CH_LP);
        pop_it    = (mode_reg == MODE_FLUSH) ||
                    (mode_reg == MODE_BIN && rank_of(ram_rdata) >= rank_of(op_reg)) ||
                    (mode_reg == MODE_CLOSE && ram_rdata != CH_LP);
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        sp_next         = sp_reg;
        op_next         = op_reg;
        bad_next        = bad_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        pend_stat_next  = pend_stat_reg;
        fin_valid_next  = fin_valid_reg;
        fin_char_next   = fin_char_reg;
        fin_stat_next   = fin_stat_reg;
        fin_clear_next  = fin_clear_reg;
        oval_next       = oval_reg && !m_tready;
        ochar_next      = ochar_reg;
        ocount_next     = ocount_reg;
        ostat_next      = ostat_reg;
        olast_next      = olast_reg;
        ram_we          = 1'b0;
        ram_waddr       = sp_reg[AW-1:0];
        ram_wdata       = op_reg;
        ram_re          = 1'b0;
        ram_raddr       = sp_m1[AW-1:0];
        let_cmd.mark    = 1'b0;
        let_cmd.clear   = 1'b0;
        let_cmd.ch      = s_tdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    fin_valid_next = 1'b0;
                    fin_clear_next = 1'b0;
                    fin_char_next  = CH_NUL;
                    fin_stat_next  = ST_OK;
                    op_next        = s_tdata;
                    bad_next       = 1'b0;
                    priority if (s_tlast)
                    begin
                        mode_next = MODE_FLUSH;
                        if (sp_reg != '0)
                        begin
                            ram_re     = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            fin_valid_next = 1'b1;
                            fin_clear_next = 1'b1;
                            state_next     = S_TAIL;
                        end
                    end
                    else if (is_letter)
                    begin
                        let_cmd.mark   = 1'b1;
                        fin_valid_next = 1'b1;
                        fin_char_next  = s_tdata;
                        state_next     = S_TAIL;
                    end
                    else if (is_unary)
                    begin
                        // full stack drops the request silently
                        if (sp_reg < SP_FULL)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = s_tdata;
                            sp_next   = sp_reg + SP_ONE;
                        end
                    end
                    else if (is_binary)
                    begin
                        mode_next = MODE_BIN;
                        if (sp_reg != '0)
                        begin
                            ram_re     = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = s_tdata;
                            sp_next   = SP_ONE;
                        end
                    end
                    else if (s_tdata == CH_RP)
                    begin
                        mode_next = MODE_CLOSE;
                        if (sp_reg != '0)
                        begin
                            ram_re     = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            fin_valid_next = 1'b1;
                            fin_stat_next  = ST_UNBAL;
                            state_next     = S_TAIL;
                        end
                    end
                    else if (s_tdata == CH_SP || s_tdata == CH_NL)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        fin_valid_next = 1'b1;
                        fin_char_next  = s_tdata;
                        fin_stat_next  = ST_UNKNOWN;
                        state_next     = S_TAIL;
                    end
                end
            end

            S_READ:
            begin
                if (pop_it)
                begin
                    // a popped entry waits in pend until we know whether it ends the run
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            oval_next   = 1'b1;
                            ochar_next  = pend_char_reg;
                            ostat_next  = pend_stat_reg;
                            ocount_next = let_count;
                            olast_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_char_next  = ram_rdata;
                        pend_stat_next  = top_bad ? ST_UNBAL : ST_OK;
                        bad_next        = bad_reg || top_bad;
                        sp_next         = sp_m1;
                        if (sp_reg > SP_ONE)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = sp_m2[AW-1:0];
                        end
                        else
                        begin
                            state_next = S_TAIL;
                            unique case (mode_reg)
                                MODE_BIN:
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = '0;
                                    sp_next   = SP_ONE;
                                end
                                MODE_CLOSE:
                                begin
                                    fin_valid_next = 1'b1;
                                    fin_stat_next  = ST_UNBAL;
                                end
                                MODE_FLUSH:
                                begin
                                    fin_valid_next = 1'b1;
                                    fin_clear_next = 1'b1;
                                    fin_stat_next  = (bad_reg || top_bad) ? ST_UNBAL : ST_OK;
                                end
                                default:
                                begin
                                    fin_valid_next = 1'b0;
                                end
                            endcase
                        end
                    end
                end
                else
                begin
                    state_next = S_TAIL;
                    if (mode_reg == MODE_CLOSE)
                    begin
                        sp_next = sp_m1;
                    end
                    else if (sp_reg < SP_FULL)
                    begin
                        ram_we  = 1'b1;
                        sp_next = sp_reg + SP_ONE;
                    end
                end
            end

            S_TAIL:
            begin
                priority if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        oval_next       = 1'b1;
                        ochar_next      = pend_char_reg;
                        ostat_next      = pend_stat_reg;
                        ocount_next     = let_count;
                        olast_next      = !fin_valid_reg;
                        pend_valid_next = 1'b0;
                        if (!fin_valid_reg)
                            state_next = S_IDLE;
                    end
                end
                else if (fin_valid_reg)
                begin
                    if (out_free)
                    begin
                        oval_next      = 1'b1;
                        ochar_next     = fin_char_reg;
                        ostat_next     = fin_stat_reg;
                        ocount_next    = let_count;
                        olast_next     = 1'b1;
                        fin_valid_next = 1'b0;
                        let_cmd.clear  = fin_clear_reg;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_BIN;
            sp_reg         <= '0;
            bad_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            fin_valid_reg  <= 1'b0;
            fin_clear_reg  <= 1'b0;
            oval_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            sp_reg         <= sp_next;
            bad_reg        <= bad_next;
            pend_valid_reg <= pend_valid_next;
            fin_valid_reg  <= fin_valid_next;
            fin_clear_reg  <= fin_clear_next;
            oval_reg       <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pend_char_reg <= pend_char_next;
        pend_stat_reg <= pend_stat_next;
        fin_char_reg  <= fin_char_next;
        fin_stat_reg  <= fin_stat_next;
        ochar_reg     <= ochar_next;
        ocount_reg    <= ocount_next;
        ostat_reg     <= ostat_next;
        olast_reg     <= olast_next;
    end

    assign m_tvalid = oval_reg;
    assign m_tdata  = {ostat_reg, ocount_reg, ochar_reg};
    assign m_tlast  = olast_reg;

`ifndef SYNTH
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond depth");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> sp_reg != '0)
        else $error("stack read with empty stack");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("stack write and read in one cycle");

    a_pend_context: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_READ || state_reg == S_TAIL))
        else $error("pending pop left behind in idle");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAIL && fin_clear_reg && fin_valid_reg) |-> sp_reg == '0)
        else $error("terminator with non-empty stack");
`endif

endmodule
`default_nettype wire

>>> sv/bool_infix_to_postfix_top.sv
// Top level of the boolean infix-to-postfix converter.
// A letter or unknown character goes from the idle state through the tail state to the output;
// '~', '-', '(', blanks and a binary operator on an empty stack are handled in idle alone. A
// binary operator, ')' and the end marker on a non-empty stack read and pop the stack in the
// read state, then finish in the tail state. One read port pops one entry per cycle while the
// output accepts; output stalls hold the pops. The output register lets the next request in.
// Reset clears control, stack pointer and the letter map; stack RAM contents stay undefined.
`default_nettype none
module bool_infix_to_postfix_top
    import bip_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // end_of_expr
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [7:0] out_char, [13:8] var_count, [15:14] status
    output logic             m_tlast    // last
);

    localparam int AW = $clog2(STACK_DEPTH);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    bip_let_cmd_t  let_cmd;
    logic [5:0]    let_count;

    bip_ctrl #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .ram_re   (ram_re),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata),
        .let_cmd  (let_cmd),
        .let_count(let_count)
    );

    bip_ram #(
        .WIDTH(8),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    bip_letters u_letters (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (let_cmd),
        .count(let_count)
    );

endmodule
`default_nettype wire
